// ----- rtl/aqg_pkg.sv -----
// shared widths, codes and constants of the adaptive quality governor
package aqg_pkg;

   // window depth and derived widths
   localparam int HISTORY_DEPTH = 32;
   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   // field widths
   localparam int FT_W = 20;
   localparam int SUM_W = FT_W + $clog2(HISTORY_DEPTH);
   localparam int TIME_W = 32;
   localparam int MEM_W = 16;
   localparam int LEVEL_W = 3;
   localparam int DROP_W = 32;
   localparam int INTV_W = 10;
   localparam int THR_W = INTV_W + LEVEL_W;
   localparam int OUT_SUM_W = 25;
   localparam int OUT_CNT_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W = 32;

   // operation codes
   localparam logic OP_GATE = 1'b0;
   localparam logic OP_DONE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ADAPTIVE_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEMORY_BUDGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;

   // register reset values
   localparam logic RST_ADAPTIVE_ENABLED = 1'b1;
   localparam logic [MEM_W-1:0] RST_MEMORY_BUDGET = 16'd512;
   localparam logic [INTV_W-1:0] RST_MIN_INTERVAL = 10'd16;

   // level bounds
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_GATE = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_MEM_FLOOR = 3'd1;
   localparam logic [LEVEL_W-1:0] GATE_SCALE_BASE = 3'd4;

   // rate and sampling constants
   localparam int RATE_LOW = 25;
   localparam int RATE_HIGH = 35;
   localparam int US_PER_S = 1000000;
   localparam logic [TIME_W-1:0] SAMPLE_PERIOD_MS = 32'd1000;

   // window totals after the current word
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } win_stat_type;

endpackage

// ----- rtl/aqg_if.sv -----
// channel interfaces of the adaptive quality governor

interface aqg_req_if import aqg_pkg::*; ();
   logic valid;
   logic ready;
   logic operation;
   logic [TIME_W-1:0] time_ms;
   logic [FT_W-1:0] frame_time_us;
   logic [MEM_W-1:0] memory_mb;

   modport source(output valid, operation, time_ms, frame_time_us, memory_mb,
      input ready);
   modport sink(input valid, operation, time_ms, frame_time_us, memory_mb,
      output ready);
endinterface

interface aqg_rsp_if import aqg_pkg::*; ();
   logic valid;
   logic ready;
   logic process_frame;
   logic [LEVEL_W-1:0] quality_level;
   logic [DROP_W-1:0] dropped_count;
   logic memory_over;
   logic [OUT_SUM_W-1:0] window_sum_us;
   logic [OUT_CNT_W-1:0] window_count;

   modport source(output valid, process_frame, quality_level, dropped_count,
      memory_over, window_sum_us, window_count, input ready);
   modport sink(input valid, process_frame, quality_level, dropped_count,
      memory_over, window_sum_us, window_count, output ready);
endinterface

interface aqg_csr_if import aqg_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/aqg_window.sv -----
// sliding window of frame times with running sum and fill count
module aqg_window import aqg_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [FT_W-1:0] frame_time,
   output win_stat_type stat_next
);

   logic [FT_W-1:0] window_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic full;
   logic [FT_W-1:0] oldest;

   assign full = (fill_ff >= CNT_W'(HISTORY_DEPTH));
   // only read once the window is full, so every entry read was written
   assign oldest = full ? window_ff[slot_ff] : '0;

   always_comb begin
      sum_in = sum_ff;
      fill_in = fill_ff;
      slot_in = slot_ff;
      if (push) begin
         sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(frame_time);
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   assign stat_next.sum = sum_in;
   assign stat_next.count = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         fill_ff <= '0;
         slot_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         fill_ff <= fill_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         window_ff[slot_ff] <= frame_time;
      end
   end

endmodule

// ----- rtl/adaptive_quality_governor.sv -----
// top level: frame gate, frame time window, memory sample and quality level
// a req word passes the input register and then the result register before its rsp word is valid
// throughput: one word per cycle while rsp is not stalled; all per-word work sits between the two registers
// a result waiting on rsp does not block req until the input register is also full
// reset: synchronous, active high; level 5, counters, window totals and samples cleared,
// config registers to enabled, 512 MB budget, 16 ms interval; window entries are not cleared
module adaptive_quality_governor import aqg_pkg::*; (
   input logic clock,
   input logic reset,
   aqg_req_if.sink req_chan,
   aqg_rsp_if.source rsp_chan,
   aqg_csr_if.sink csr_chan
);

   // config registers
   logic enable_ff;
   logic [MEM_W-1:0] budget_ff;
   logic [INTV_W-1:0] min_intv_ff;

   // input register
   logic in_v_ff, in_v_in;
   logic op_ff;
   logic [TIME_W-1:0] now_ff;
   logic [FT_W-1:0] ft_ff;
   logic [MEM_W-1:0] mem_ff;

   // governor state
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [TIME_W-1:0] last_pass_ff, last_pass_in;
   logic [TIME_W-1:0] last_sample_ff, last_sample_in;
   logic [MEM_W-1:0] latched_ff, latched_in;
   logic [DROP_W-1:0] drop_ff, drop_in;

   // result register
   logic out_v_ff, out_v_in;
   logic pass_ff;
   logic [LEVEL_W-1:0] qlev_ff;
   logic [DROP_W-1:0] dcnt_ff;
   logic over_ff;
   logic [OUT_SUM_W-1:0] wsum_ff;
   logic [OUT_CNT_W-1:0] wcnt_ff;

   logic req_fire, fire, push;
   logic [TIME_W-1:0] elapsed_pass, elapsed_sample;
   logic [THR_W-1:0] gate_thr;
   logic drop;
   logic sample_due;
   logic mem_over;
   win_stat_type stat_next;
   logic [PROD_W-1:0] scaled, low_prod, high_prod;
   logic rate_low, rate_high;
   logic [LEVEL_W-1:0] lev_rate;

   // handshakes: compute stage moves when the result register is free or draining
   assign fire = in_v_ff && (!out_v_ff || rsp_chan.ready);
   assign req_chan.ready = !in_v_ff || fire;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign in_v_in = req_fire || (in_v_ff && !fire);
   assign out_v_in = fire || (out_v_ff && !rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   // only done words enter the window
   assign push = fire && (op_ff == OP_DONE);

   aqg_window u_window (
      .clock(clock),
      .reset(reset),
      .push(push),
      .frame_time(ft_ff),
      .stat_next(stat_next)
   );

   // gate: drop while adapting at low level and the interval is not yet over
   assign elapsed_pass = now_ff - last_pass_ff;
   assign gate_thr = THR_W'(min_intv_ff) * THR_W'(GATE_SCALE_BASE - level_ff);
   assign drop = (op_ff == OP_GATE) && enable_ff && (level_ff < LEVEL_GATE) &&
      (elapsed_pass < TIME_W'(gate_thr));

   // memory sample, wrapping time difference
   assign elapsed_sample = now_ff - last_sample_ff;
   assign sample_due = (op_ff == OP_DONE) && (elapsed_sample > SAMPLE_PERIOD_MS);
   assign latched_in = (fire && sample_due) ? mem_ff : latched_ff;
   assign last_sample_in = (fire && sample_due) ? now_ff : last_sample_ff;
   assign mem_over = (latched_in > budget_ff);

   // fps compare without division: 25*sum vs 1e6*count and 35*sum vs 1e6*count
   assign scaled = PROD_W'(stat_next.count) * PROD_W'(US_PER_S);
   assign low_prod = PROD_W'(stat_next.sum) * PROD_W'(RATE_LOW);
   assign high_prod = PROD_W'(stat_next.sum) * PROD_W'(RATE_HIGH);
   assign rate_low = (stat_next.sum == '0) || (low_prod > scaled);
   assign rate_high = (high_prod < scaled);

   always_comb begin
      lev_rate = level_ff;
      if (rate_low) begin
         if (level_ff > LEVEL_MIN) begin
            lev_rate = level_ff - 1'b1;
         end
      end else if (rate_high && (level_ff < LEVEL_MAX)) begin
         lev_rate = level_ff + 1'b1;
      end
   end

   always_comb begin
      level_in = level_ff;
      last_pass_in = last_pass_ff;
      drop_in = drop_ff;
      if (fire) begin
         if (op_ff == OP_GATE) begin
            if (drop) begin
               drop_in = drop_ff + 1'b1;
            end else begin
               last_pass_in = now_ff;
            end
         end else if (enable_ff) begin
            // memory pressure takes one more step after the rate rule
            level_in = (mem_over && (lev_rate > LEVEL_MEM_FLOOR)) ? lev_rate - 1'b1 :
               lev_rate;
         end
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= RST_ADAPTIVE_ENABLED;
         budget_ff <= RST_MEMORY_BUDGET;
         min_intv_ff <= RST_MIN_INTERVAL;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            REG_ADAPTIVE_ENABLED: enable_ff <= csr_chan.data[0];
            REG_MEMORY_BUDGET: budget_ff <= csr_chan.data[MEM_W-1:0];
            REG_MIN_INTERVAL: min_intv_ff <= csr_chan.data[INTV_W-1:0];
            default: ;
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         level_ff <= LEVEL_MAX;
         last_pass_ff <= '0;
         last_sample_ff <= '0;
         latched_ff <= '0;
         drop_ff <= '0;
      end else begin
         in_v_ff <= in_v_in;
         out_v_ff <= out_v_in;
         level_ff <= level_in;
         last_pass_ff <= last_pass_in;
         last_sample_ff <= last_sample_in;
         latched_ff <= latched_in;
         drop_ff <= drop_in;
      end
   end

   // input word payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_chan.operation;
         now_ff <= req_chan.time_ms;
         ft_ff <= req_chan.frame_time_us;
         mem_ff <= req_chan.memory_mb;
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (fire) begin
         pass_ff <= !drop;
         qlev_ff <= level_in;
         dcnt_ff <= drop_in;
         over_ff <= mem_over;
         wsum_ff <= OUT_SUM_W'(stat_next.sum);
         wcnt_ff <= OUT_CNT_W'(stat_next.count);
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.process_frame = pass_ff;
   assign rsp_chan.quality_level = qlev_ff;
   assign rsp_chan.dropped_count = dcnt_ff;
   assign rsp_chan.memory_over = over_ff;
   assign rsp_chan.window_sum_us = wsum_ff;
   assign rsp_chan.window_count = wcnt_ff;

endmodule

// ----- tb/adaptive_quality_governor_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the adaptive quality governor: directed table, then random phases
module adaptive_quality_governor_tb;
   import aqg_pkg::*;

   // unmapped register index, a write there must leave every setting alone
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int IDLE_PCT = 22;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 192;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic op;
      logic [TIME_W-1:0] t;
      logic [FT_W-1:0] ft;
      logic [MEM_W-1:0] mem;
   } frame_event_type;

   typedef struct packed {
      logic pass;
      logic [LEVEL_W-1:0] level;
      logic [DROP_W-1:0] drops;
      logic over;
      logic [OUT_SUM_W-1:0] sum;
      logic [OUT_CNT_W-1:0] cnt;
   } governor_status_type;

   typedef struct packed {
      frame_event_type ev;
      logic typed;
      governor_status_type want;
   } directed_row_type;

   // frame time profile held for a burst of done words
   typedef enum logic [1:0] {PACE_FAST, PACE_SLOW, PACE_STEADY, PACE_WILD} pace_type;

   // directed words, run from reset with the default settings (enabled, 512 MB, 16 ms)
   // rows with typed set carry an expectation that is plain from reset
   localparam int SCRIPT_LEN = 18;
   localparam directed_row_type SCRIPT [SCRIPT_LEN] = '{
      // gate right after reset at level 5 always passes
      '{'{OP_GATE, 32'd0, 20'd0, 16'd0}, 1'b1, '{1'b1, 3'd5, 32'd0, 1'b0, 25'd0, 6'd0}},
      // zero frame time gives an empty sum, which counts as a low rate
      '{'{OP_DONE, 32'd5, 20'd0, 16'd0}, 1'b1, '{1'b1, 3'd4, 32'd0, 1'b0, 25'd0, 6'd1}},
      // longest frame time, memory sample due with the largest usage: rate and memory fall
      '{'{OP_DONE, 32'd1006, 20'hFFFFF, 16'hFFFF}, 1'b0, '0},
      // level 2 now: pass, two drops, then a pass at exactly the interval
      '{'{OP_GATE, 32'd1010, 20'h00000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'd1020, 20'hFFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{OP_GATE, 32'd1041, 20'h00000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'd1042, 20'hFFFFF, 16'hFFFF}, 1'b0, '0},
      // exactly 1000 ms since the sample is not yet due, 1001 ms is
      '{'{OP_DONE, 32'd2006, 20'hFFFFF, 16'h0000}, 1'b0, '0},
      '{'{OP_DONE, 32'd2007, 20'h00000, 16'h0000}, 1'b0, '0},
      // level 0: widest gate interval
      '{'{OP_GATE, 32'd2007, 20'h00000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'd2008, 20'h00000, 16'h0000}, 1'b0, '0},
      // clock wraps between passes
      '{'{OP_GATE, 32'hFFFF_FFF0, 20'h00000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'h0000_0005, 20'h00000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'h0000_0030, 20'h00000, 16'h0000}, 1'b0, '0},
      // memory sample across the wrap, then none, then one again
      '{'{OP_DONE, 32'hFFFF_FFFF, 20'h00001, 16'hFFFF}, 1'b0, '0},
      '{'{OP_DONE, 32'hFFFF_FFFF, 20'd28571, 16'h0000}, 1'b0, '0},
      '{'{OP_DONE, 32'h0000_0400, 20'd40000, 16'h0000}, 1'b0, '0},
      '{'{OP_GATE, 32'h0000_0400, 20'hFFFFF, 16'hFFFF}, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic calm;   // no idling on either side while set
   int mismatch_count;

   aqg_req_if req_bus ();
   aqg_rsp_if rsp_bus ();
   aqg_csr_if csr_bus ();

   adaptive_quality_governor dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // settings as the block should hold them
   logic gov_enabled;
   logic [MEM_W-1:0] mem_budget;
   logic [INTV_W-1:0] gate_interval;

   // governor state as the block should hold it
   logic [LEVEL_W-1:0] quality;
   logic [FT_W-1:0] frame_hist [HISTORY_DEPTH];
   logic [SUM_W-1:0] hist_sum;
   int hist_fill;
   logic [SLOT_W-1:0] hist_slot;
   logic [TIME_W-1:0] last_pass_ms;
   logic [TIME_W-1:0] last_sample_ms;
   logic [MEM_W-1:0] mem_latched;
   logic [DROP_W-1:0] drop_total;

   // status words still owed by the block, oldest first
   governor_status_type outcome_q [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // advance the governor by one word and return the status it should report
   function automatic governor_status_type predict_outcome(input frame_event_type ev);
      logic [TIME_W-1:0] gap;
      int unsigned limit;
      longint unsigned rate_sum;
      longint unsigned rate_ref;
      governor_status_type s;
      s.pass = 1'b1;
      if (ev.op == OP_GATE) begin
         gap = ev.t - last_pass_ms;
         // the interval is scaled only when the level is low enough to gate at all
         limit = (quality < LEVEL_GATE) ?
            int'(gate_interval) * (int'(GATE_SCALE_BASE) - int'(quality)) : 0;
         if (gov_enabled && quality < LEVEL_GATE && gap < limit) begin
            drop_total = drop_total + 1'b1;
            s.pass = 1'b0;
         end else begin
            last_pass_ms = ev.t;
         end
      end else begin
         gap = ev.t - last_sample_ms;
         if (gap > SAMPLE_PERIOD_MS) begin
            mem_latched = ev.mem;
            last_sample_ms = ev.t;
         end
         // full window: the entry about to be overwritten leaves the sum
         if (hist_fill >= HISTORY_DEPTH)
            hist_sum = hist_sum - frame_hist[hist_slot];
         else
            hist_fill++;
         frame_hist[hist_slot] = ev.ft;
         hist_sum = hist_sum + ev.ft;
         hist_slot = hist_slot + 1'b1;
         if (gov_enabled) begin
            // fps compares as integer products: fps < 25 and fps > 35
            rate_sum = hist_sum;
            rate_ref = longint'(hist_fill) * US_PER_S;
            if (rate_sum == 0 || rate_sum * RATE_LOW > rate_ref) begin
               if (quality > LEVEL_MIN)
                  quality = quality - 1'b1;
            end else if (rate_sum * RATE_HIGH < rate_ref && quality < LEVEL_MAX) begin
               quality = quality + 1'b1;
            end
            if (mem_latched > mem_budget && quality > LEVEL_MEM_FLOOR)
               quality = quality - 1'b1;
         end
      end
      s.level = quality;
      s.drops = drop_total;
      s.over = mem_latched > mem_budget;
      s.sum = OUT_SUM_W'(hist_sum);
      s.cnt = OUT_CNT_W'(hist_fill);
      return s;
   endfunction

   // offer one word, idling at random first; returns at the edge that accepts it
   task automatic send_word(input frame_event_type ev, input logic typed,
      input governor_status_type want);
      governor_status_type s;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= ev.op;
      req_bus.time_ms <= ev.t;
      req_bus.frame_time_us <= ev.ft;
      req_bus.memory_mb <= ev.mem;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // the predictor always runs so its state follows the block
      s = predict_outcome(ev);
      outcome_q = {outcome_q, (typed ? want : s)};
   endtask

   // one register write; valid is left high so writes can follow back to back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
      input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_ADAPTIVE_ENABLED: gov_enabled = val[0];
         REG_MEMORY_BUDGET: mem_budget = val[MEM_W-1:0];
         REG_MIN_INTERVAL: gate_interval = val[INTV_W-1:0];
         default: ;
      endcase
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // result side: stalls at random, except in the calm phase
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // every accepted status word is held against the oldest one owed
   always @(posedge clock) begin : status_check
      governor_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, got pass %0d level %0d drops %0d",
               $time, rsp_bus.process_frame, rsp_bus.quality_level, rsp_bus.dropped_count);
            mismatch_count++;
         end else begin
            want = outcome_q.pop_front();
            check_field("process_frame", 32'(want.pass), 32'(rsp_bus.process_frame));
            check_field("quality_level", 32'(want.level), 32'(rsp_bus.quality_level));
            check_field("dropped_count", 32'(want.drops), 32'(rsp_bus.dropped_count));
            check_field("memory_over", 32'(want.over), 32'(rsp_bus.memory_over));
            check_field("window_sum_us", 32'(want.sum), 32'(rsp_bus.window_sum_us));
            check_field("window_count", 32'(want.cnt), 32'(rsp_bus.window_count));
         end
      end
   end

   // hard limit on the whole run
   initial begin
      #(4_000_000);
      $display("adaptive_quality_governor_tb: errors");
      $finish;
   end

   initial begin
      int i;
      int p;
      int n;
      int r;
      int pace_left;
      pace_type pace;
      frame_event_type ev;
      logic [TIME_W-1:0] clock_ms;
      logic cfg_en;
      logic [MEM_W-1:0] cfg_budget;
      logic [INTV_W-1:0] cfg_intv;

      mismatch_count = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_GATE;
      req_bus.time_ms = '0;
      req_bus.frame_time_us = '0;
      req_bus.memory_mb = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_ADAPTIVE_ENABLED;
      csr_bus.data = '0;

      // predictor at its reset point
      gov_enabled = RST_ADAPTIVE_ENABLED;
      mem_budget = RST_MEMORY_BUDGET;
      gate_interval = RST_MIN_INTERVAL;
      quality = LEVEL_MAX;
      foreach (frame_hist[k]) frame_hist[k] = '0;
      hist_sum = '0;
      hist_fill = 0;
      hist_slot = '0;
      last_pass_ms = '0;
      last_sample_ms = '0;
      mem_latched = '0;
      drop_total = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (i = 0; i < SCRIPT_LEN; i++)
         send_word(SCRIPT[i].ev, SCRIPT[i].typed, SCRIPT[i].want);

      // random phases, each under its own settings
      clock_ms = 32'h0000_0400;
      pace = PACE_FAST;
      pace_left = 0;
      for (p = 0; p < PHASES; p++) begin
         // settings change only with the block drained
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while (outcome_q.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);

         case (p)
            0: begin cfg_en = 1'b1; cfg_budget = 16'd512; cfg_intv = 10'd16; end
            1: begin cfg_en = 1'b0; cfg_budget = 16'd0; cfg_intv = 10'd1000; end
            2: begin cfg_en = 1'b1; cfg_budget = 16'd0; cfg_intv = 10'd0; end
            3: begin cfg_en = 1'b1; cfg_budget = 16'hFFFF; cfg_intv = 10'h3FF; end
            4: begin cfg_en = 1'b1; cfg_budget = 16'd300; cfg_intv = 10'd50; end
            default: begin
               cfg_en = ($urandom_range(0, 3) != 0);
               cfg_budget = 16'($urandom);
               cfg_intv = $urandom_range(0, 1) ? 10'($urandom_range(0, 64)) :
                  10'($urandom_range(0, 1023));
            end
         endcase
         // bits above each register's width are random and must be dropped
         write_reg(REG_ADAPTIVE_ENABLED, {15'($urandom), cfg_en});
         write_reg(REG_MEMORY_BUDGET, cfg_budget);
         write_reg(REG_MIN_INTERVAL, {6'($urandom), cfg_intv});
         if (p == 0)
            write_reg(REG_SPARE, 16'($urandom));
         csr_bus.valid <= 1'b0;

         // one long stretch with no idling on either side
         calm = (p == 4);

         for (n = 0; n < PHASE_WORDS; n++) begin
            // hold off mid-phase until every owed word has come back
            if (p == 2 && n == PHASE_WORDS / 2) begin
               req_bus.valid <= 1'b0;
               @(posedge clock);
               while (outcome_q.size() != 0) @(posedge clock);
            end

            // clock mostly steps around the gate interval, sometimes near the
            // sample period, rarely anywhere including across the wrap
            r = $urandom_range(0, 99);
            if (r < 2)
               clock_ms = $urandom;
            else if (r < 6)
               clock_ms = clock_ms + TIME_W'($urandom_range(995, 1005));
            else
               clock_ms = clock_ms + TIME_W'($urandom_range(0, 4 * gate_interval + 8));

            // frame times come in bursts so the level really travels
            if (pace_left == 0) begin
               pace = pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(8, 48);
            end
            pace_left--;

            ev.op = $urandom_range(0, 1) ? OP_DONE : OP_GATE;
            ev.t = clock_ms;
            case (pace)
               PACE_FAST: ev.ft = FT_W'($urandom_range(0, 28000));
               PACE_SLOW: ev.ft = FT_W'($urandom_range(40001, 120000));
               PACE_STEADY: ev.ft = FT_W'($urandom_range(28572, 40000));
               default: begin
                  case ($urandom_range(0, 4))
                     0: ev.ft = '0;
                     1: ev.ft = '1;
                     2: ev.ft = FT_W'(40000);
                     3: ev.ft = FT_W'(28571);
                     default: ev.ft = FT_W'($urandom);
                  endcase
               end
            endcase
            // memory either anywhere or right around the budget
            if ($urandom_range(0, 1))
               ev.mem = MEM_W'($urandom);
            else
               ev.mem = mem_budget + MEM_W'($urandom_range(0, 4)) - MEM_W'(2);

            send_word(ev, 1'b0, '0);
         end
      end

      // wait out the owed words, then the pipeline
      req_bus.valid <= 1'b0;
      calm = 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("adaptive_quality_governor_tb: clean");
      else
         $display("adaptive_quality_governor_tb: errors");
      $finish;
   end

endmodule
